/* rtl/ohl_pkg.sv */
// Shared types, widths and codes for the ordered handle list.
package ohl_pkg;

  // List size and derived widths
  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Word field widths
  localparam int OP_W        = 4;
  localparam int POS_W       = 11;
  localparam int HANDLE_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 11;

  // Width used to compare a position against the count
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Reduction tree: groups of cells, then one level over the groups
  localparam int GROUP_SIZE = 32;
  localparam int GRP_W      = $clog2(GROUP_SIZE);
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NG_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int FULL_IDX_W = NG_W + GRP_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 4'd0,
    OP_INSERT = 4'd1,
    OP_ERASE  = 4'd2,
    OP_GET    = 4'd3,
    OP_SET    = 4'd4,
    OP_EXIST  = 4'd5,
    OP_REMOVE = 4'd6,
    OP_POP    = 4'd7,
    OP_CLEAR  = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REDUCE,
    S_EXEC
  } state_t;

  // Per-cell update mode of the broadcast command
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_WRITE,
    CM_SHIFT_UP,
    CM_SHIFT_DOWN
  } cmd_mode_t;

  // Broadcast update command. WRITE: cell lo takes data.
  // SHIFT_UP: cell lo takes data, cells lo < i <= hi take the left neighbor.
  // SHIFT_DOWN: cells lo <= i < hi take the right neighbor.
  typedef struct packed {
    cmd_mode_t             mode;
    logic [IDX_W-1:0]      lo;
    logic [CNT_W-1:0]      hi;
    logic [HANDLE_W-1:0]   data;
  } cell_cmd_t;

  // Broadcast search and read probe
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [CNT_W-1:0]    count;
    logic [IDX_W-1:0]    sel;
  } probe_t;

endpackage

/* rtl/ohl_if.sv */
// Request and result channel interfaces of the ordered handle list.
interface ohl_req_if;
  logic                           valid;
  logic                           ready;
  logic [ohl_pkg::OP_W-1:0]       op;
  logic [ohl_pkg::POS_W-1:0]      position;
  logic [ohl_pkg::HANDLE_W-1:0]   handle;

  modport source (output valid, output op, output position, output handle, input ready);
  modport sink   (input valid, input op, input position, input handle, output ready);
endinterface

interface ohl_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ohl_pkg::STATUS_W-1:0]     status;
  logic                             found;
  logic [ohl_pkg::HANDLE_W-1:0]     read_value;
  logic [ohl_pkg::COUNT_OUT_W-1:0]  new_count;

  modport source (output valid, output status, output found, output read_value,
                  output new_count, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input new_count, output ready);
endinterface

/* rtl/ohl_cell.sv */
// One list entry: holds a handle, shifts with its neighbors, answers probes.
module ohl_cell (
  input  logic                              clk,
  input  logic [ohl_pkg::IDX_W-1:0]         index,
  input  ohl_pkg::cell_cmd_t                cmd,
  input  ohl_pkg::probe_t                   probe,
  input  logic [ohl_pkg::HANDLE_W-1:0]      left_value,
  input  logic [ohl_pkg::HANDLE_W-1:0]      right_value,
  output logic [ohl_pkg::HANDLE_W-1:0]      value,
  output logic                              match,
  output logic [ohl_pkg::HANDLE_W-1:0]      read_out
);

  logic [ohl_pkg::HANDLE_W-1:0] value_next;
  logic [ohl_pkg::CNT_W-1:0]    idx_c;
  logic [ohl_pkg::CNT_W-1:0]    lo_c;

  assign idx_c = ohl_pkg::CNT_W'(index);
  assign lo_c  = ohl_pkg::CNT_W'(cmd.lo);

  // Update from the broadcast command
  always_comb begin
    value_next = value;
    case (cmd.mode)
      ohl_pkg::CM_WRITE: begin
        if (index == cmd.lo) value_next = cmd.data;
      end
      ohl_pkg::CM_SHIFT_UP: begin
        if (index == cmd.lo) begin
          value_next = cmd.data;
        end else if (idx_c > lo_c && idx_c <= cmd.hi) begin
          value_next = left_value;
        end
      end
      ohl_pkg::CM_SHIFT_DOWN: begin
        if (idx_c >= lo_c && idx_c < cmd.hi) value_next = right_value;
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Probe answers: live-entry match and selected read
  assign match    = (idx_c < probe.count) && (value == probe.handle);
  assign read_out = (index == probe.sel) ? value : '0;

endmodule

/* rtl/ohl_group.sv */
// First registered reduction level: first match and selected word over one group of cells.
module ohl_group (
  input  logic                                                  clk,
  input  logic [ohl_pkg::GROUP_SIZE-1:0]                        match,
  input  logic [ohl_pkg::GROUP_SIZE-1:0][ohl_pkg::HANDLE_W-1:0] read_in,
  output logic                                                  any,
  output logic [ohl_pkg::GRP_W-1:0]                             first,
  output logic [ohl_pkg::HANDLE_W-1:0]                          read_value
);

  logic [ohl_pkg::GRP_W-1:0]    first_next;
  logic [ohl_pkg::HANDLE_W-1:0] read_next;

  // Lowest matching slot wins
  always_comb begin
    first_next = '0;
    for (int k = ohl_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
      if (match[k]) first_next = ohl_pkg::GRP_W'(k);
    end
  end

  // At most one slot is selected, so OR merges
  always_comb begin
    read_next = '0;
    for (int k = 0; k < ohl_pkg::GROUP_SIZE; k++) begin
      read_next = read_next | read_in[k];
    end
  end

  always_ff @(posedge clk) begin
    any        <= |match;
    first      <= first_next;
    read_value <= read_next;
  end

endmodule

/* rtl/ordered_handle_list_unit.sv */
// Ordered handle list: row of entry cells, two-level search tree and request sequencer.
// Append, insert, erase, set, clear and unused codes: from accept straight to execute, where the result is registered.
// Get, pop, exist and remove: first through scan and reduce, the two registered levels of the match/read tree.
// A new word is taken at the earliest the cycle after the previous one executes, so words never overlap.
// A pending result does not block acceptance; execution waits for the result register.
// Reset clears the count and the control; entry contents stay unknown until written.
module ordered_handle_list_unit (
  input  logic       clk,
  input  logic       rst,
  ohl_req_if.sink    req,
  ohl_rsp_if.source  rsp
);

  localparam int NUM_SLOTS = ohl_pkg::NUM_GROUPS * ohl_pkg::GROUP_SIZE;

  ohl_pkg::state_t state;
  ohl_pkg::state_t state_next;

  // Captured request
  ohl_pkg::op_t                    op_r;
  logic [ohl_pkg::POS_W-1:0]       pos_r;
  logic [ohl_pkg::HANDLE_W-1:0]    handle_r;

  logic [ohl_pkg::CNT_W-1:0]       count;
  logic [ohl_pkg::CNT_W-1:0]       count_next;

  // Second reduction level results
  logic                            found_r;
  logic [ohl_pkg::IDX_W-1:0]       match_idx_r;
  logic [ohl_pkg::HANDLE_W-1:0]    rd_r;
  logic                            l2_found;
  logic [ohl_pkg::FULL_IDX_W-1:0]  l2_idx;
  logic [ohl_pkg::HANDLE_W-1:0]    l2_read;

  // Result register
  logic                            out_valid;
  ohl_pkg::status_t                out_status;
  logic                            out_found;
  logic [ohl_pkg::HANDLE_W-1:0]    out_read;
  logic [ohl_pkg::COUNT_OUT_W-1:0] out_count;

  ohl_pkg::status_t                res_status;
  logic                            res_found;
  logic [ohl_pkg::HANDLE_W-1:0]    res_read;

  logic                            in_ready;
  logic                            exec_fire;

  ohl_pkg::cell_cmd_t              cmd_calc;
  ohl_pkg::cell_cmd_t              cell_cmd;
  ohl_pkg::probe_t                 probe;

  logic [ohl_pkg::HANDLE_W-1:0]    cell_value [ohl_pkg::CAPACITY];
  wire  [ohl_pkg::NUM_GROUPS-1:0][ohl_pkg::GROUP_SIZE-1:0] slot_match;
  wire  [ohl_pkg::NUM_GROUPS-1:0][ohl_pkg::GROUP_SIZE-1:0][ohl_pkg::HANDLE_W-1:0] slot_read;

  logic                            grp_any   [ohl_pkg::NUM_GROUPS];
  logic [ohl_pkg::GRP_W-1:0]       grp_first [ohl_pkg::NUM_GROUPS];
  logic [ohl_pkg::HANDLE_W-1:0]    grp_read  [ohl_pkg::NUM_GROUPS];

  logic [ohl_pkg::CMP_W-1:0]       pos_c;
  logic [ohl_pkg::CMP_W-1:0]       cnt_c;
  logic                            is_full;
  logic                            is_empty;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ohl_pkg::S_IDLE: begin
        if (req.valid) begin
          case (ohl_pkg::op_t'(req.op)) inside
            ohl_pkg::OP_GET, ohl_pkg::OP_POP, ohl_pkg::OP_EXIST, ohl_pkg::OP_REMOVE:
              state_next = ohl_pkg::S_SCAN;
            default:
              state_next = ohl_pkg::S_EXEC;
          endcase
        end
      end
      ohl_pkg::S_SCAN:   state_next = ohl_pkg::S_REDUCE;
      ohl_pkg::S_REDUCE: state_next = ohl_pkg::S_EXEC;
      ohl_pkg::S_EXEC: begin
        if (!out_valid || rsp.ready) state_next = ohl_pkg::S_IDLE;
      end
      default: state_next = ohl_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      ohl_pkg::S_IDLE:   in_ready  = 1'b1;
      ohl_pkg::S_EXEC:   exec_fire = !out_valid || rsp.ready;
      default: begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ohl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (req.valid && in_ready) begin
      op_r     <= ohl_pkg::op_t'(req.op);
      pos_r    <= req.position;
      handle_r <= req.handle;
    end
  end

  // Probe: search handle, live count, read select (last entry for pop)
  always_comb begin
    probe.handle = handle_r;
    probe.count  = count;
    probe.sel    = (op_r == ohl_pkg::OP_POP) ? ohl_pkg::IDX_W'(count - ohl_pkg::CNT_W'(1))
                                             : ohl_pkg::IDX_W'(pos_r);
  end

  // Row of cells, padded to whole groups
  for (genvar c = 0; c < NUM_SLOTS; c++) begin : g_slot
    if (c < ohl_pkg::CAPACITY) begin : g_used
      logic [ohl_pkg::HANDLE_W-1:0] left_v;
      logic [ohl_pkg::HANDLE_W-1:0] right_v;
      logic                         match_v;
      logic [ohl_pkg::HANDLE_W-1:0] read_v;

      if (c == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_mid
        assign left_v = cell_value[c-1];
      end
      if (c == ohl_pkg::CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_inner
        assign right_v = cell_value[c+1];
      end

      ohl_cell u_cell (
        .clk         (clk),
        .index       (ohl_pkg::IDX_W'(c)),
        .cmd         (cell_cmd),
        .probe       (probe),
        .left_value  (left_v),
        .right_value (right_v),
        .value       (cell_value[c]),
        .match       (match_v),
        .read_out    (read_v)
      );

      assign slot_match[c / ohl_pkg::GROUP_SIZE][c % ohl_pkg::GROUP_SIZE] = match_v;
      assign slot_read[c / ohl_pkg::GROUP_SIZE][c % ohl_pkg::GROUP_SIZE]  = read_v;
    end else begin : g_pad
      assign slot_match[c / ohl_pkg::GROUP_SIZE][c % ohl_pkg::GROUP_SIZE] = 1'b0;
      assign slot_read[c / ohl_pkg::GROUP_SIZE][c % ohl_pkg::GROUP_SIZE]  = '0;
    end
  end

  // First reduction level
  for (genvar g = 0; g < ohl_pkg::NUM_GROUPS; g++) begin : g_group
    ohl_group u_group (
      .clk        (clk),
      .match      (slot_match[g]),
      .read_in    (slot_read[g]),
      .any        (grp_any[g]),
      .first      (grp_first[g]),
      .read_value (grp_read[g])
    );
  end

  // Second reduction level over the groups
  always_comb begin
    l2_found = 1'b0;
    l2_idx   = '0;
    l2_read  = '0;
    for (int g = ohl_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        l2_found = 1'b1;
        l2_idx   = {ohl_pkg::NG_W'(g), grp_first[g]};
      end
    end
    for (int g = 0; g < ohl_pkg::NUM_GROUPS; g++) begin
      l2_read = l2_read | grp_read[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ohl_pkg::S_REDUCE) begin
      found_r     <= l2_found;
      match_idx_r <= ohl_pkg::IDX_W'(l2_idx);
      rd_r        <= l2_read;
    end
  end

  // Execute: checks, result fields, cell command and new count
  assign pos_c    = ohl_pkg::CMP_W'(pos_r);
  assign cnt_c    = ohl_pkg::CMP_W'(count);
  assign is_full  = (count == ohl_pkg::CNT_W'(ohl_pkg::CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    res_status    = ohl_pkg::ST_OK;
    res_found     = 1'b0;
    res_read      = '0;
    count_next    = count;
    cmd_calc.mode = ohl_pkg::CM_HOLD;
    cmd_calc.lo   = ohl_pkg::IDX_W'(pos_r);
    cmd_calc.hi   = count;
    cmd_calc.data = handle_r;
    unique case (op_r)
      ohl_pkg::OP_APPEND: begin
        if (is_full) begin
          res_status = ohl_pkg::ST_FULL;
        end else begin
          cmd_calc.mode = ohl_pkg::CM_WRITE;
          cmd_calc.lo   = ohl_pkg::IDX_W'(count);
          count_next    = count + ohl_pkg::CNT_W'(1);
        end
      end
      ohl_pkg::OP_INSERT: begin
        if (pos_c > cnt_c) begin
          res_status = ohl_pkg::ST_RANGE;
        end else if (is_full) begin
          res_status = ohl_pkg::ST_FULL;
        end else begin
          cmd_calc.mode = ohl_pkg::CM_SHIFT_UP;
          count_next    = count + ohl_pkg::CNT_W'(1);
        end
      end
      ohl_pkg::OP_ERASE: begin
        if (pos_c >= cnt_c) begin
          res_status = ohl_pkg::ST_RANGE;
        end else begin
          cmd_calc.mode = ohl_pkg::CM_SHIFT_DOWN;
          cmd_calc.hi   = count - ohl_pkg::CNT_W'(1);
          count_next    = count - ohl_pkg::CNT_W'(1);
        end
      end
      ohl_pkg::OP_GET: begin
        if (pos_c >= cnt_c) begin
          res_status = ohl_pkg::ST_RANGE;
        end else begin
          res_read = rd_r;
        end
      end
      ohl_pkg::OP_SET: begin
        if (pos_c >= cnt_c) begin
          res_status = ohl_pkg::ST_RANGE;
        end else begin
          cmd_calc.mode = ohl_pkg::CM_WRITE;
        end
      end
      ohl_pkg::OP_EXIST: begin
        res_found = found_r;
      end
      ohl_pkg::OP_REMOVE: begin
        res_found = found_r;
        if (found_r) begin
          cmd_calc.mode = ohl_pkg::CM_SHIFT_DOWN;
          cmd_calc.lo   = match_idx_r;
          cmd_calc.hi   = count - ohl_pkg::CNT_W'(1);
          count_next    = count - ohl_pkg::CNT_W'(1);
        end
      end
      ohl_pkg::OP_POP: begin
        if (is_empty) begin
          res_status = ohl_pkg::ST_EMPTY;
        end else begin
          res_read   = rd_r;
          count_next = count - ohl_pkg::CNT_W'(1);
        end
      end
      ohl_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        res_status = ohl_pkg::ST_OK;
      end
    endcase
  end

  // Cells move only in the execute cycle
  always_comb begin
    cell_cmd = cmd_calc;
    if (!exec_fire) cell_cmd.mode = ohl_pkg::CM_HOLD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_fire) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_read   <= res_read;
      out_count  <= ohl_pkg::COUNT_OUT_W'(count_next);
    end
  end

  assign req.ready      = in_ready;
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found      = out_found;
  assign rsp.read_value = out_read;
  assign rsp.new_count  = out_count;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ohl_pkg::CNT_W'(ohl_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_count_matches_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.new_count == ohl_pkg::COUNT_OUT_W'(count))
    else $error("pending result count differs from list count");

  a_count_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    !exec_fire |=> $stable(count))
    else $error("count changed outside execute");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != ohl_pkg::S_IDLE)
    else $error("sequencer idle right after accepting a word");

  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == ohl_pkg::ST_OK && rsp.read_value == '0)
    else $error("found result carries status or read data");

endmodule

/* verif/ordered_handle_list_unit_tb.sv */
// Self-checking testbench for the ordered handle list: directed table, random mix, full-list pass.
module ordered_handle_list_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ohl_pkg::*;

  // Op codes the block ignores
  localparam logic [OP_W-1:0]  OP_FIRST_UNUSED = 4'd9;
  localparam logic [OP_W-1:0]  OP_LAST_UNUSED  = 4'd15;
  localparam logic [POS_W-1:0] POS_MAX         = '1;
  localparam int               MIXED_ITEMS     = 900;
  localparam int               DIR_ROWS        = 26;

  // One result word
  typedef struct packed {
    status_t                 status;
    logic                    found;
    logic [HANDLE_W-1:0]     read_value;
    logic [COUNT_OUT_W-1:0]  new_count;
  } list_result_t;

  // Directed row: request, plus a hand-written result where one is given
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [POS_W-1:0]     position;
    logic [HANDLE_W-1:0]  handle;
    logic                 typed;
    list_result_t         want;
  } dir_row_t;

  localparam dir_row_t DIR_PLAN [DIR_ROWS] = '{
    // empty list right after reset
    '{OP_POP,          11'd0,    32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 32'h0, 11'd0}},
    '{OP_GET,          11'd0,    32'h0000_0000, 1'b1, '{ST_RANGE, 1'b0, 32'h0, 11'd0}},
    '{OP_ERASE,        11'd0,    32'h0000_0000, 1'b1, '{ST_RANGE, 1'b0, 32'h0, 11'd0}},
    '{OP_SET,          11'd0,    32'hFFFF_FFFF, 1'b1, '{ST_RANGE, 1'b0, 32'h0, 11'd0}},
    '{OP_EXIST,        11'd0,    32'hFFFF_FFFF, 1'b1, '{ST_OK,    1'b0, 32'h0, 11'd0}},
    '{OP_REMOVE,       11'd0,    32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 32'h0, 11'd0}},
    '{OP_INSERT,       11'd1,    32'hDEAD_BEEF, 1'b1, '{ST_RANGE, 1'b0, 32'h0, 11'd0}},
    // build a small list: insert at front, at count, in the middle
    '{OP_INSERT,       11'd0,    32'hFFFF_FFFF, 1'b0, '0},
    '{OP_APPEND,       11'd0,    32'h0000_0000, 1'b0, '0},
    '{OP_INSERT,       11'd2,    32'hA5A5_A5A5, 1'b0, '0},
    '{OP_INSERT,       11'd1,    32'h5A5A_5A5A, 1'b0, '0},
    '{OP_GET,          11'd3,    32'h0000_0000, 1'b0, '0},
    '{OP_GET,          11'd4,    32'h0000_0000, 1'b1, '{ST_RANGE, 1'b0, 32'h0, 11'd4}},
    '{OP_GET,          POS_MAX,  32'h0000_0000, 1'b1, '{ST_RANGE, 1'b0, 32'h0, 11'd4}},
    '{OP_SET,          11'd2,    32'h1234_5678, 1'b0, '0},
    '{OP_EXIST,        11'd0,    32'h1234_5678, 1'b0, '0},
    // duplicate handle: remove takes the lowest match only
    '{OP_APPEND,       11'd0,    32'h5A5A_5A5A, 1'b0, '0},
    '{OP_REMOVE,       11'd0,    32'h5A5A_5A5A, 1'b0, '0},
    '{OP_GET,          11'd1,    32'h0000_0000, 1'b0, '0},
    '{OP_ERASE,        11'd0,    32'h0000_0000, 1'b0, '0},
    '{OP_POP,          11'd0,    32'h0000_0000, 1'b0, '0},
    '{OP_FIRST_UNUSED, POS_MAX,  32'hFFFF_FFFF, 1'b1, '{ST_OK,    1'b0, 32'h0, 11'd2}},
    '{OP_LAST_UNUSED,  11'd0,    32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 32'h0, 11'd2}},
    // clear leaves stale words that must not be readable
    '{OP_CLEAR,        11'd0,    32'h0000_0000, 1'b0, '0},
    '{OP_GET,          11'd0,    32'h0000_0000, 1'b1, '{ST_RANGE, 1'b0, 32'h0, 11'd0}},
    '{OP_POP,          11'd0,    32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 32'h0, 11'd0}}
  };

  logic clk = 1'b0;
  logic rst;

  ohl_req_if req_ch ();
  ohl_rsp_if rsp_ch ();

  ordered_handle_list_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the list
  logic [HANDLE_W-1:0] shadow_list [CAPACITY];
  int                  shadow_count;

  list_result_t awaited_results [$];
  int           mismatch_count;
  int           stall_left;
  bit           calm;

  // Mostly short gaps, a few long ones
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Small values repeat often so searches see duplicates
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return HANDLE_W'($urandom_range(0, 7));
    if (roll == 3) return $urandom_range(0, 1) ? '1 : '0;
    return $urandom;
  endfunction

  // Apply one request to the shadow list and return its result
  function automatic list_result_t predict_request(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [HANDLE_W-1:0] handle);
    list_result_t r;
    int           hit;
    r   = '0;
    r.status = ST_OK;
    hit = -1;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = handle;
          shadow_count++;
        end
      end
      OP_INSERT: begin
        if (int'(pos) > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > int'(pos); i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = handle;
          shadow_count++;
        end
      end
      OP_ERASE: begin
        if (int'(pos) >= shadow_count) r.status = ST_RANGE;
        else hit = pos;
      end
      OP_GET: begin
        if (int'(pos) >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_list[pos];
      end
      OP_SET: begin
        if (int'(pos) >= shadow_count) r.status = ST_RANGE;
        else shadow_list[pos] = handle;
      end
      OP_EXIST, OP_REMOVE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (!r.found && shadow_list[i] == handle) begin
            r.found = 1'b1;
            if (op == OP_REMOVE) hit = i;
          end
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          r.read_value = shadow_list[shadow_count];
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    // erase and remove close the gap
    if (hit >= 0) begin
      for (int i = hit; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
      shadow_count--;
    end
    r.new_count = COUNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // Drive one request word, wait for accept, then queue what it should return
  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [HANDLE_W-1:0] handle, input logic typed,
                           input list_result_t want);
    list_result_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.handle   <= handle;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_request(op, pos, handle);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= gap_length() - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    list_result_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status     = status_t'(rsp_ch.status);
      got.found      = rsp_ch.found;
      got.read_value = rsp_ch.read_value;
      got.new_count  = rsp_ch.new_count;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result word with nothing expected: st=%0d f=%0b rd=%h cnt=%0d",
                   $realtime, got.status, got.found, got.read_value, got.new_count);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.read_value !== want.read_value || got.new_count !== want.new_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: want st=%0d f=%0b rd=%h cnt=%0d, got st=%0d f=%0b rd=%h cnt=%0d",
                     $realtime, want.status, want.found, want.read_value, want.new_count,
                     got.status, got.found, got.read_value, got.new_count);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [OP_W-1:0]     op;
    logic [POS_W-1:0]    pos;
    logic [HANDLE_W-1:0] handle;
    int                  roll;
    int                  lim;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_APPEND;
    req_ch.position = '0;
    req_ch.handle   = '0;
    rsp_ch.ready    = 1'b0;
    shadow_count    = 0;
    mismatch_count  = 0;
    stall_left      = 0;
    calm            = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int k = 0; k < DIR_ROWS; k++)
      send_word(DIR_PLAN[k].op, DIR_PLAN[k].position, DIR_PLAN[k].handle,
                DIR_PLAN[k].typed, DIR_PLAN[k].want);

    // Random mix on a short list, with one excursion to a full list halfway
    for (int n = 0; n < MIXED_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);

      if (n == MIXED_ITEMS / 2) begin
        send_word(OP_CLEAR, '0, '0, 1'b0, '0);
        while (shadow_count < CAPACITY)
          send_word(OP_APPEND, POS_W'($urandom), $urandom, 1'b0, '0);
        send_word(OP_APPEND, '0, $urandom, 1'b0, '0);
        send_word(OP_INSERT, '0, $urandom, 1'b0, '0);
        send_word(OP_INSERT, POS_W'(CAPACITY), $urandom, 1'b0, '0);
        send_word(OP_INSERT, POS_W'(CAPACITY + 1), $urandom, 1'b0, '0);
        send_word(OP_GET, POS_W'(CAPACITY - 1), '0, 1'b0, '0);
        send_word(OP_GET, POS_W'(CAPACITY), '0, 1'b0, '0);
        send_word(OP_SET, POS_W'(CAPACITY - 1), $urandom, 1'b0, '0);
        send_word(OP_EXIST, '0, shadow_list[CAPACITY-1], 1'b0, '0);
        send_word(OP_REMOVE, '0, shadow_list[$urandom_range(CAPACITY / 2, CAPACITY - 1)],
                  1'b0, '0);
        send_word(OP_INSERT, '0, $urandom, 1'b0, '0);
        send_word(OP_GET, POS_W'(CAPACITY - 1), '0, 1'b0, '0);
        send_word(OP_POP, '0, '0, 1'b0, '0);
        send_word(OP_ERASE, '0, '0, 1'b0, '0);
        send_word(OP_GET, POS_MAX, '0, 1'b0, '0);
        send_word(OP_CLEAR, '0, '0, 1'b0, '0);
      end

      // op choice, leaning toward shrinking ops once the list grows
      roll = $urandom_range(0, 99);
      if (roll < 18)      op = OP_APPEND;
      else if (roll < 32) op = OP_INSERT;
      else if (roll < 44) op = OP_ERASE;
      else if (roll < 56) op = OP_GET;
      else if (roll < 66) op = OP_SET;
      else if (roll < 76) op = OP_EXIST;
      else if (roll < 86) op = OP_REMOVE;
      else if (roll < 94) op = OP_POP;
      else if (roll < 96) op = OP_CLEAR;
      else op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      if (shadow_count > 40 && (op == OP_APPEND || op == OP_INSERT) && $urandom_range(0, 1))
        op = OP_POP;

      // position: mostly in range, sometimes on or past the boundary
      roll = $urandom_range(0, 19);
      lim  = (op == OP_INSERT) ? shadow_count : shadow_count - 1;
      if (roll < 14 && lim >= 0) pos = POS_W'($urandom_range(0, lim));
      else if (roll < 16)        pos = POS_W'(shadow_count);
      else if (roll < 17)        pos = POS_W'(shadow_count + 1);
      else                       pos = POS_W'($urandom_range(0, POS_MAX));

      // searches mostly look for a handle that is present
      if ((op == OP_EXIST || op == OP_REMOVE) && shadow_count > 0 && $urandom_range(0, 9) < 6)
        handle = shadow_list[$urandom_range(0, shadow_count - 1)];
      else
        handle = pick_handle();

      send_word(op, pos, handle, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    // Drain, then watch a little longer for stray words
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
